### hw/rtl/skyang_pkg.sv
// Shared constants, types and helper functions for the sky angle to pixel core.
package skyang_pkg;

  localparam int MAX_ORDER = 13;
  localparam int CORDIC_STEPS = 30;
  localparam logic [31:0] THETA_PI = 32'd3373259426;
  localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic [31:0] SQRT6_Q30 = 32'd2630119584;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  typedef logic [3:0] order_t;

  typedef logic signed [31:0] atan_tab_t [0:CORDIC_STEPS-1];
  localparam atan_tab_t ATAN_Q30 = '{
    32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6, 32'sh03FEAB76,
    32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55, 32'sh003FFFEA, 32'sh001FFFFD,
    32'sh000FFFFF, 32'sh0007FFFF, 32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF,
    32'sh00007FFF, 32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
    32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F, 32'sh0000003F,
    32'sh0000001F, 32'sh0000000F, 32'sh00000008, 32'sh00000004, 32'sh00000002
  };

  // Spread 16 bits onto the even positions of a 32-bit word.
  function automatic logic [31:0] spread16(input logic [15:0] v);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[2*i] = v[i];
    end
    return r;
  endfunction

endpackage

### hw/rtl/sky_angle_to_pixel_core.sv
// Top level of the sky angle to pixel core: input stage, CORDIC, pixel back end.
// Takes a colatitude theta (unsigned Q2.30 rad) and longitude phi (signed Q4.28
// rad) per transaction and returns the nested HEALPix pixel index for nside =
// 2^map_order (order clamped to 13). One transaction enters per cycle unless
// the output stalls. The pipeline has one input stage (theta clamp, phi to
// quarter-turns multiply), 30 CORDIC iteration stages, and six back-end
// stages (squares, cos(theta), region split, polar products, face and edge
// lines, Morton packing into the output register). A stall on the master side
// freezes the whole pipeline in place, so nothing is dropped or repeated. Write
// map_order only while no transaction is in flight.
module sky_angle_to_pixel_core
  import skyang_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        map_order_we,
  input  logic [3:0]  map_order,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] theta_angle, [63:32] phi_angle
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [29:0] pixel_index, [31:30] zero
);

  order_t order_reg, ord;
  always_ff @(posedge clk) begin
    if (rst) order_reg <= '0;
    else if (map_order_we) order_reg <= map_order;
  end
  assign ord = (order_reg > order_t'(MAX_ORDER)) ? order_t'(MAX_ORDER) : order_reg;

  // Advance every stage whenever the output register is free or being drained.
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Input stage: clamp theta, scale phi into Q2.30 quarter-turns.
  logic [31:0]        theta_cl;
  logic signed [65:0] phi_prod;
  assign theta_cl = (s_tdata[31:0] > THETA_PI) ? THETA_PI : s_tdata[31:0];
  assign phi_prod = $signed({s_tdata[63], s_tdata[63:32]})
                  * $signed({1'b0, TWO_OVER_PI_Q32});

  logic               in_v;
  logic signed [31:0] in_ang;
  logic [31:0]        in_tt;
  always_ff @(posedge clk) begin
    if (rst) in_v <= 1'b0;
    else if (adv) in_v <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      in_ang <= $signed({1'b0, theta_cl[31:1]});
      in_tt  <= phi_prod[61:30];
    end
  end

  logic               cx_v;
  logic signed [31:0] cx_x, cx_y;
  logic [31:0]        cx_tt;
  skyang_cordic u_cordic (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(in_v), .in_ang(in_ang), .in_tag(in_tt),
    .out_valid(cx_v), .out_x(cx_x), .out_y(cx_y), .out_tag(cx_tt)
  );

  logic [29:0] pix;
  skyang_pixel u_pixel (
    .clk(clk), .rst(rst), .adv(adv), .ord(ord),
    .in_valid(cx_v), .in_x(cx_x), .in_y(cx_y), .in_tt(cx_tt),
    .out_valid(m_tvalid), .out_pix(pix)
  );

  assign m_tdata = {2'b00, pix};

  // Hold the result and its valid while the sink stalls.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed during stall");
  // Reset empties the pipeline.
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("valid after reset");
  // Refuse input while the sink stalls the output.
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken during stall");

endmodule

### hw/rtl/skyang_cordic.sv
// Pipelined rotation CORDIC, one iteration per register stage, with a sideband tag.
module skyang_cordic
  import skyang_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [31:0] in_ang,
  input  logic [31:0]        in_tag,
  output logic               out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic [31:0]        out_tag
);

  logic               v   [0:CORDIC_STEPS];
  logic signed [31:0] x   [0:CORDIC_STEPS];
  logic signed [31:0] y   [0:CORDIC_STEPS];
  logic signed [31:0] a   [0:CORDIC_STEPS];
  logic [31:0]        tag [0:CORDIC_STEPS];

  assign v[0]   = in_valid;
  assign x[0]   = CORDIC_GAIN;
  assign y[0]   = '0;
  assign a[0]   = in_ang;
  assign tag[0] = in_tag;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (adv) begin
        v[i+1] <= v[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        tag[i+1] <= tag[i];
        if (!a[i][31]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          a[i+1] <= a[i] - ATAN_Q30[i];
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          a[i+1] <= a[i] + ATAN_Q30[i];
        end
      end
    end
  end

  assign out_valid = v[CORDIC_STEPS];
  assign out_x     = x[CORDIC_STEPS];
  assign out_y     = y[CORDIC_STEPS];
  assign out_tag   = tag[CORDIC_STEPS];

endmodule

### hw/rtl/skyang_pixel.sv
// Pixel back end: cos(theta), region split, edge-line indices and nested index.
module skyang_pixel
  import skyang_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  order_t             ord,
  input  logic               in_valid,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic [31:0]        in_tt,
  output logic               out_valid,
  output logic [29:0]        out_pix
);

  logic [15:0] mask;
  assign mask = 16'((17'd1 << ord) - 17'd1);

  // clamp and square
  logic [30:0] c_cl, s_cl;
  assign c_cl = in_x[31] ? '0 : (in_x > $signed({1'b0, Q30_ONE})) ? Q30_ONE : in_x[30:0];
  assign s_cl = in_y[31] ? '0 : (in_y > $signed({1'b0, Q30_ONE})) ? Q30_ONE : in_y[30:0];

  logic        m_v;
  logic [61:0] m_cc, m_ss;
  logic [30:0] m_c, m_s;
  logic [31:0] m_tt;
  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else if (adv) m_v <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_cc <= c_cl * c_cl;
      m_ss <= s_cl * s_cl;
      m_c  <= c_cl;
      m_s  <= s_cl;
      m_tt <= in_tt;
    end
  end

  // z = cos(theta) in Q30
  logic signed [62:0] diff;
  assign diff = $signed({1'b0, m_cc}) - $signed({1'b0, m_ss});

  logic               z_v;
  logic signed [31:0] z_z;
  logic [30:0]        z_c, z_s;
  logic [31:0]        z_tt;
  always_ff @(posedge clk) begin
    if (rst) z_v <= 1'b0;
    else if (adv) z_v <= m_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      z_z  <= diff[61:30];
      z_c  <= m_c;
      z_s  <= m_s;
      z_tt <= m_tt;
    end
  end

  // region test, equatorial offsets, polar radius
  logic [31:0]        za;
  logic signed [36:0] t1, t2, dp, dm;
  logic [30:0]        sp;
  logic [62:0]        rprod;
  assign za    = z_z[31] ? 32'(-z_z) : z_z;
  assign t1    = 37'sh8000_0000 + $signed({3'b0, z_tt, 2'b0});
  assign t2    = 37'(z_z) * 37'sd3;
  assign dp    = t1 - t2;
  assign dm    = t1 + t2;
  assign sp    = z_z[31] ? z_c : z_s;
  assign rprod = sp * SQRT6_Q30;

  logic        p1_v, p1_eq, p1_neg;
  logic [35:0] p1_dp, p1_dm;
  logic [31:0] p1_r, p1_tt;
  always_ff @(posedge clk) begin
    if (rst) p1_v <= 1'b0;
    else if (adv) p1_v <= z_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_eq  <= (34'(za) * 34'd3) <= 34'h8000_0000;
      p1_neg <= z_z[31];
      p1_dp  <= dp[36] ? '0 : dp[35:0];
      p1_dm  <= dm[36] ? '0 : dm[35:0];
      p1_r   <= rprod[61:30];
      p1_tt  <= z_tt;
    end
  end

  // polar products and equatorial line indices
  logic [35:0] eq_jp_w, eq_jm_w;
  assign eq_jp_w = p1_dp >> (6'd32 - 6'(ord));
  assign eq_jm_w = p1_dm >> (6'd32 - 6'(ord));

  logic        p2_v, p2_eq, p2_neg;
  logic [15:0] p2_ejp, p2_ejm;
  logic [2:0]  p2_ifp, p2_ifm;
  logic [1:0]  p2_ntt;
  logic [62:0] p2_pp, p2_pm;
  always_ff @(posedge clk) begin
    if (rst) p2_v <= 1'b0;
    else if (adv) p2_v <= p1_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p2_eq  <= p1_eq;
      p2_neg <= p1_neg;
      p2_ejp <= eq_jp_w[15:0];
      p2_ejm <= eq_jm_w[15:0];
      p2_ifp <= p1_dp[34:32];
      p2_ifm <= p1_dm[34:32];
      p2_ntt <= p1_tt[31:30];
      p2_pp  <= {1'b0, p1_tt[29:0]} * p1_r;
      p2_pm  <= (Q30_ONE - {1'b0, p1_tt[29:0]}) * p1_r;
    end
  end

  // face and x/y indices
  logic [62:0] pjp_w, pjm_w;
  logic [15:0] pjp, pjm;
  assign pjp_w = p2_pp >> (6'd60 - 6'(ord));
  assign pjm_w = p2_pm >> (6'd60 - 6'(ord));
  assign pjp   = (pjp_w > 63'(mask)) ? mask : pjp_w[15:0];
  assign pjm   = (pjm_w > 63'(mask)) ? mask : pjm_w[15:0];

  logic [3:0]  face;
  logic [15:0] ix, iy;
  always_comb begin
    if (p2_eq) begin
      if (p2_ifp == p2_ifm) face = {1'b0, p2_ifp | 3'd4};
      else if (p2_ifp < p2_ifm) face = {1'b0, p2_ifp};
      else face = {1'b0, p2_ifm} + 4'd8;
      ix = p2_ejm & mask;
      iy = ~p2_ejp & mask;
    end else if (!p2_neg) begin
      face = {2'b0, p2_ntt};
      ix   = ~pjm & mask;
      iy   = ~pjp & mask;
    end else begin
      face = {2'b0, p2_ntt} + 4'd8;
      ix   = pjp;
      iy   = pjm;
    end
  end

  logic        p3_v;
  logic [3:0]  p3_face;
  logic [15:0] p3_ix, p3_iy;
  always_ff @(posedge clk) begin
    if (rst) p3_v <= 1'b0;
    else if (adv) p3_v <= p2_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p3_face <= face;
      p3_ix   <= ix;
      p3_iy   <= iy;
    end
  end

  logic [33:0] nest;
  assign nest = ({30'b0, p3_face} << {ord, 1'b0}) + {2'b0, spread16(p3_ix)}
              + {1'b0, spread16(p3_iy), 1'b0};

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= p3_v;
  end
  always_ff @(posedge clk) begin
    if (adv) out_pix <= nest[29:0];
  end

endmodule
